### rtl/rau_pkg.sv
`default_nettype none

package rau_pkg;

   // Operand and datapath widths
   localparam int OPERAND_WIDTH   = 16;
   localparam int PRODUCT_WIDTH   = 2 * OPERAND_WIDTH;
   localparam int RESULT_WIDTH    = 34;
   localparam int DIV_COUNT_WIDTH = $clog2(RESULT_WIDTH + 1);
   localparam int COMMAND_WIDTH   = 3;

   typedef enum logic [COMMAND_WIDTH-1:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_EQ  = 3'd4,
      CMD_GT  = 3'd5,
      CMD_LT  = 3'd6
   } cmd_type;

   // Which cross product the shared multiplier forms
   typedef enum logic [1:0] {
      MUL_LN_RD = 2'd0,
      MUL_LD_RN = 2'd1,
      MUL_LN_RN = 2'd2,
      MUL_LD_RD = 2'd3
   } mul_sel_type;

   // Which operand pair goes to the divider
   typedef enum logic [1:0] {
      DIV_GCD = 2'd0,
      DIV_NUM = 2'd1,
      DIV_DEN = 2'd2
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_FORM,
      ST_CHECK,
      ST_GCD_TEST,
      ST_GCD_WAIT,
      ST_QNUM_WAIT,
      ST_QDEN_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        mul_load;
      mul_sel_type mul_sel;
      logic        form;
      logic        div_start;
      div_sel_type div_sel;
      logic        gcd_step;
      logic        load_num;
      logic        load_den;
      logic        result_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic no_reduce;   // compare, multiply or unused command
      logic den_zero;
      logic d_zero;      // Euclid loop finished
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

### rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide and compare two
// signed fractions left_num/left_den and right_num/right_den.
// Request channel (req_*): one beat carries a command and four 16-bit
// two's complement operands; a beat moves when req_valid is high and
// req_stall low. Response channel (rsp_*): one beat per request carries the
// 34-bit numerator and denominator, compare_true and error.
// Add, subtract and divide results are reduced by a signed Euclid GCD with
// truncated remainder, so the denominator sign follows that rule; multiply
// is not reduced. A zero result denominator gives error with zero fields.
// Steps: the shared 16x16 multiplier forms the four cross products in turn,
// then the fraction is formed and checked; reducing commands then run one
// divider pass per Euclid step, a last test and the two divisions by the
// GCD, all on one 34-bit restoring divider at one quotient bit a cycle.
// One request is in flight at a time; req_stall is high from acceptance
// until the result is written to the response register. A finished result
// waits in the FINISH state while the response register is still held by a
// stalled receiver. Synchronous reset clears the controller and rsp_valid.
`default_nettype none

module rational_arithmetic_unit (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic [rau_pkg::COMMAND_WIDTH-1:0]         req_command,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_left_num,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_left_den,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_right_num,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_right_den,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic signed [rau_pkg::RESULT_WIDTH-1:0]        rsp_result_num,
   output logic signed [rau_pkg::RESULT_WIDTH-1:0]        rsp_result_den,
   output logic                                           rsp_compare_true,
   output logic                                           rsp_error
);

   // Controller sequences the multiplier, Euclid loop and result write
   rau_pkg::ctrl_cmd_type  ctrl;
   rau_pkg::dp_status_type status;

   rau_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .ctrl      (ctrl)
   );

   // Datapath holds operands, products, the GCD pair, the divider and
   // the response register
   rau_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_left_num     (req_left_num),
      .req_left_den     (req_left_den),
      .req_right_num    (req_right_num),
      .req_right_den    (req_right_den),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_num   (rsp_result_num),
      .rsp_result_den   (rsp_result_den),
      .rsp_compare_true (rsp_compare_true),
      .rsp_error        (rsp_error),
      .ctrl             (ctrl),
      .status           (status)
   );

endmodule

`default_nettype wire

### rtl/rau_divider.sv
`default_nettype none

// Signed truncated division, restoring, one quotient bit per cycle.
module rau_divider (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   input  wire logic signed [rau_pkg::RESULT_WIDTH-1:0] dividend,
   input  wire logic signed [rau_pkg::RESULT_WIDTH-1:0] divisor,
   output logic                                         done,
   output logic signed [rau_pkg::RESULT_WIDTH-1:0]      quotient,
   output logic signed [rau_pkg::RESULT_WIDTH-1:0]      remainder
);

   localparam int W = rau_pkg::RESULT_WIDTH;

   logic                                  busy_ff, busy_in;
   logic                                  done_ff, done_in;
   logic [rau_pkg::DIV_COUNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [W-1:0]                          quot_ff, quot_in;
   logic [W-1:0]                          rem_ff, rem_in;
   logic [W-1:0]                          dvs_ff, dvs_in;
   logic                                  neg_q_ff, neg_q_in;
   logic                                  neg_r_ff, neg_r_in;

   logic [W:0]   shifted;
   logic [W:0]   diff;
   logic         fits;
   logic [W-1:0] mag_a;
   logic [W-1:0] mag_b;

   always_comb begin
      mag_a   = dividend[W-1] ? W'(-dividend) : W'(dividend);
      mag_b   = divisor[W-1]  ? W'(-divisor)  : W'(divisor);
      shifted = {rem_ff, quot_ff[W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;

      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = rau_pkg::DIV_COUNT_WIDTH'(W);
         quot_in  = mag_a;
         rem_in   = '0;
         dvs_in   = mag_b;
         neg_q_in = dividend[W-1] ^ divisor[W-1];
         neg_r_in = dividend[W-1];
      end else if (busy_ff) begin
         quot_in = {quot_ff[W-2:0], fits};
         rem_in  = fits ? diff[W-1:0] : shifted[W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == rau_pkg::DIV_COUNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   assign done      = done_ff;
   assign quotient  = neg_q_ff ? $signed(-quot_ff) : $signed(quot_ff);
   assign remainder = neg_r_ff ? $signed(-rem_ff)  : $signed(rem_ff);

endmodule

`default_nettype wire

### rtl/rau_datapath.sv
`default_nettype none

module rau_datapath (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic [rau_pkg::COMMAND_WIDTH-1:0]         req_command,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_left_num,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_left_den,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_right_num,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_right_den,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic signed [rau_pkg::RESULT_WIDTH-1:0]        rsp_result_num,
   output logic signed [rau_pkg::RESULT_WIDTH-1:0]        rsp_result_den,
   output logic                                           rsp_compare_true,
   output logic                                           rsp_error,
   input  wire rau_pkg::ctrl_cmd_type                     ctrl,
   output rau_pkg::dp_status_type                         status
);

   localparam int OW = rau_pkg::OPERAND_WIDTH;
   localparam int PW = rau_pkg::PRODUCT_WIDTH;
   localparam int RW = rau_pkg::RESULT_WIDTH;

   // Captured operands
   rau_pkg::cmd_type      cmd_ff, cmd_in;
   logic signed [OW-1:0]  ln_ff, ln_in, ld_ff, ld_in, rn_ff, rn_in, rd_ff, rd_in;

   // Cross products
   logic signed [PW-1:0]  p_ff, p_in, q_ff, q_in, nn_ff, nn_in, dd_ff, dd_in;

   // Unreduced / reduced fraction and Euclid pair
   logic signed [RW-1:0]  num_ff, num_in, den_ff, den_in, a_ff, a_in, d_ff, d_in;

   // Result beat
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [RW-1:0]  rsp_num_ff, rsp_num_in, rsp_den_ff, rsp_den_in;
   logic                  rsp_cmp_ff, rsp_cmp_in, rsp_err_ff, rsp_err_in;

   logic signed [OW-1:0]  mul_a, mul_b;
   logic signed [PW-1:0]  mul_p;
   logic signed [RW-1:0]  form_num, form_den;
   logic                  no_reduce;
   logic                  cmp_hold;

   logic signed [RW-1:0]  div_dividend, div_divisor, div_quot, div_rem;
   logic                  div_done;

   rau_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Shared multiplier operand select
   always_comb begin
      case (ctrl.mul_sel)
         rau_pkg::MUL_LN_RD: begin mul_a = ln_ff; mul_b = rd_ff; end
         rau_pkg::MUL_LD_RN: begin mul_a = ld_ff; mul_b = rn_ff; end
         rau_pkg::MUL_LN_RN: begin mul_a = ln_ff; mul_b = rn_ff; end
         rau_pkg::MUL_LD_RD: begin mul_a = ld_ff; mul_b = rd_ff; end
         default:            begin mul_a = ln_ff; mul_b = rd_ff; end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Divider operand select
   always_comb begin
      case (ctrl.div_sel)
         rau_pkg::DIV_GCD: begin div_dividend = a_ff;   div_divisor = d_ff; end
         rau_pkg::DIV_NUM: begin div_dividend = num_ff; div_divisor = a_ff; end
         rau_pkg::DIV_DEN: begin div_dividend = den_ff; div_divisor = a_ff; end
         default:          begin div_dividend = a_ff;   div_divisor = d_ff; end
      endcase
   end

   // Fraction before reduction
   always_comb begin
      form_num = '0;
      form_den = '0;
      case (cmd_ff)
         rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
            if (ld_ff == rd_ff) begin
               form_den = RW'(ld_ff);
               form_num = (cmd_ff == rau_pkg::CMD_ADD) ? RW'(ln_ff) + RW'(rn_ff)
                                                       : RW'(ln_ff) - RW'(rn_ff);
            end else begin
               form_den = RW'(dd_ff);
               form_num = (cmd_ff == rau_pkg::CMD_ADD) ? RW'(p_ff) + RW'(q_ff)
                                                       : RW'(p_ff) - RW'(q_ff);
            end
         end
         rau_pkg::CMD_MUL: begin
            form_num = RW'(nn_ff);
            form_den = RW'(dd_ff);
         end
         rau_pkg::CMD_DIV: begin
            form_num = RW'(p_ff);
            form_den = RW'(q_ff);
         end
         default: begin
            form_num = '0;
            form_den = '0;
         end
      endcase
   end

   always_comb begin
      case (cmd_ff)
         rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_DIV: no_reduce = 1'b0;
         default:                                              no_reduce = 1'b1;
      endcase
      case (cmd_ff)
         rau_pkg::CMD_EQ: cmp_hold = (p_ff == q_ff);
         rau_pkg::CMD_GT: cmp_hold = (p_ff > q_ff);
         rau_pkg::CMD_LT: cmp_hold = (p_ff < q_ff);
         default:         cmp_hold = 1'b0;
      endcase
   end

   always_comb begin
      cmd_in = cmd_ff;
      ln_in  = ln_ff;
      ld_in  = ld_ff;
      rn_in  = rn_ff;
      rd_in  = rd_ff;
      p_in   = p_ff;
      q_in   = q_ff;
      nn_in  = nn_ff;
      dd_in  = dd_ff;
      num_in = num_ff;
      den_in = den_ff;
      a_in   = a_ff;
      d_in   = d_ff;

      if (ctrl.capture) begin
         cmd_in = rau_pkg::cmd_type'(req_command);
         ln_in  = req_left_num;
         ld_in  = req_left_den;
         rn_in  = req_right_num;
         rd_in  = req_right_den;
      end
      if (ctrl.mul_load) begin
         case (ctrl.mul_sel)
            rau_pkg::MUL_LN_RD: p_in  = mul_p;
            rau_pkg::MUL_LD_RN: q_in  = mul_p;
            rau_pkg::MUL_LN_RN: nn_in = mul_p;
            rau_pkg::MUL_LD_RD: dd_in = mul_p;
            default:            p_in  = mul_p;
         endcase
      end
      if (ctrl.form) begin
         num_in = form_num;
         den_in = form_den;
         a_in   = form_num;
         d_in   = form_den;
      end
      if (ctrl.gcd_step) begin
         a_in = d_ff;
         d_in = div_rem;
      end
      if (ctrl.load_num) begin
         num_in = div_quot;
      end
      if (ctrl.load_den) begin
         den_in = div_quot;
      end
   end

   // Result beat; the denominator is zero on an error, a compare or an unused command
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_err_in   = rsp_err_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.result_load) begin
         rsp_valid_in = 1'b1;
         rsp_num_in   = '0;
         rsp_den_in   = '0;
         rsp_cmp_in   = 1'b0;
         rsp_err_in   = 1'b0;
         case (cmd_ff)
            rau_pkg::CMD_EQ, rau_pkg::CMD_GT, rau_pkg::CMD_LT: begin
               rsp_cmp_in = cmp_hold;
            end
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB, rau_pkg::CMD_MUL, rau_pkg::CMD_DIV: begin
               if (den_ff == '0) begin
                  rsp_err_in = 1'b1;
               end else begin
                  rsp_num_in = num_ff;
                  rsp_den_in = den_ff;
               end
            end
            default: begin
               rsp_cmp_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      ln_ff      <= ln_in;
      ld_ff      <= ld_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      nn_ff      <= nn_in;
      dd_ff      <= dd_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      a_ff       <= a_in;
      d_ff       <= d_in;
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
      rsp_cmp_ff <= rsp_cmp_in;
      rsp_err_ff <= rsp_err_in;
   end

   always_comb begin
      status.no_reduce = no_reduce;
      status.den_zero  = (den_ff == '0);
      status.d_zero    = (d_ff == '0);
      status.div_done  = div_done;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_num   = rsp_num_ff;
   assign rsp_result_den   = rsp_den_ff;
   assign rsp_compare_true = rsp_cmp_ff;
   assign rsp_error        = rsp_err_ff;

endmodule

`default_nettype wire

### rtl/rau_controller.sv
`default_nettype none

module rau_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire rau_pkg::dp_status_type status,
   output rau_pkg::ctrl_cmd_type       ctrl
);

   rau_pkg::state_type state_ff, state_in;
   logic [1:0]         mul_idx_ff, mul_idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rau_pkg::ST_IDLE;
         mul_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         mul_idx_ff <= mul_idx_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mul_idx_in = mul_idx_ff;
      req_stall  = 1'b1;
      ctrl       = '0;
      ctrl.mul_sel = rau_pkg::mul_sel_type'(mul_idx_ff);
      ctrl.div_sel = rau_pkg::DIV_GCD;

      case (state_ff)
         rau_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               mul_idx_in   = '0;
               state_in     = rau_pkg::ST_MUL;
            end
         end
         rau_pkg::ST_MUL: begin
            ctrl.mul_load = 1'b1;
            mul_idx_in    = mul_idx_ff + 1'b1;
            if (mul_idx_ff == 2'(rau_pkg::MUL_LD_RD)) begin
               state_in = rau_pkg::ST_FORM;
            end
         end
         rau_pkg::ST_FORM: begin
            ctrl.form = 1'b1;
            state_in  = rau_pkg::ST_CHECK;
         end
         rau_pkg::ST_CHECK: begin
            if (status.no_reduce || status.den_zero) begin
               state_in = rau_pkg::ST_FINISH;
            end else begin
               state_in = rau_pkg::ST_GCD_TEST;
            end
         end
         rau_pkg::ST_GCD_TEST: begin
            ctrl.div_start = 1'b1;
            if (status.d_zero) begin
               ctrl.div_sel = rau_pkg::DIV_NUM;
               state_in     = rau_pkg::ST_QNUM_WAIT;
            end else begin
               ctrl.div_sel = rau_pkg::DIV_GCD;
               state_in     = rau_pkg::ST_GCD_WAIT;
            end
         end
         rau_pkg::ST_GCD_WAIT: begin
            if (status.div_done) begin
               ctrl.gcd_step = 1'b1;
               state_in      = rau_pkg::ST_GCD_TEST;
            end
         end
         rau_pkg::ST_QNUM_WAIT: begin
            if (status.div_done) begin
               ctrl.load_num  = 1'b1;
               ctrl.div_start = 1'b1;
               ctrl.div_sel   = rau_pkg::DIV_DEN;
               state_in       = rau_pkg::ST_QDEN_WAIT;
            end
         end
         rau_pkg::ST_QDEN_WAIT: begin
            if (status.div_done) begin
               ctrl.load_den = 1'b1;
               state_in      = rau_pkg::ST_FINISH;
            end
         end
         rau_pkg::ST_FINISH: begin
            if (status.out_free) begin
               ctrl.result_load = 1'b1;
               state_in         = rau_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rau_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/rau_checker.sv
`default_nettype none

module rau_port_checker (
   input wire logic                                      clock,
   input wire logic                                      reset,
   input wire logic                                      req_valid,
   input wire logic                                      req_stall,
   input wire logic                                      rsp_valid,
   input wire logic                                      rsp_stall,
   input wire logic signed [rau_pkg::RESULT_WIDTH-1:0]   rsp_result_num,
   input wire logic signed [rau_pkg::RESULT_WIDTH-1:0]   rsp_result_den,
   input wire logic                                      rsp_compare_true,
   input wire logic                                      rsp_error
);

   // Stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_num)
         && $stable(rsp_result_den) && $stable(rsp_compare_true) && $stable(rsp_error))
      else $error("response beat changed while stalled");

   // One request in flight: busy right after acceptance
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while busy");

   // Error beat carries zero fraction and no compare flag
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_result_num == '0 && rsp_result_den == '0
         && !rsp_compare_true)
      else $error("error beat with nonzero fields");

   // Compare result carries no fraction
   a_compare_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_result_num == '0 && rsp_result_den == '0
         && !rsp_error)
      else $error("compare beat with nonzero fraction");

endmodule

bind rational_arithmetic_unit rau_port_checker u_rau_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_num   (rsp_result_num),
   .rsp_result_den   (rsp_result_den),
   .rsp_compare_true (rsp_compare_true),
   .rsp_error        (rsp_error)
);

`default_nettype wire

### dv/rau_checker.sv
module rau_checker (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   input  wire logic                                      req_stall,
   input  wire logic [rau_pkg::COMMAND_WIDTH-1:0]         req_command,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_left_num,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_left_den,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_right_num,
   input  wire logic signed [rau_pkg::OPERAND_WIDTH-1:0]  req_right_den,
   input  wire logic                                      rsp_valid,
   input  wire logic                                      rsp_stall,
   input  wire logic signed [rau_pkg::RESULT_WIDTH-1:0]   rsp_result_num,
   input  wire logic signed [rau_pkg::RESULT_WIDTH-1:0]   rsp_result_den,
   input  wire logic                                      rsp_compare_true,
   input  wire logic                                      rsp_error,
   output int                                             fail_count,
   output int                                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] num;
      logic signed [RESULT_WIDTH-1:0] den;
      logic                           compare_true;
      logic                           error;
   } fraction_result_type;

   fraction_result_type pending_results[$];
   int                  mismatches = 0;

   // sign-extend from the 34-bit datapath
   function automatic longint wrap_datapath(longint value);
      logic signed [RESULT_WIDTH-1:0] narrow;
      narrow = value[RESULT_WIDTH-1:0];
      return longint'(narrow);
   endfunction

   function automatic fraction_result_type predict_fraction(
      logic [COMMAND_WIDTH-1:0]        op_bits,
      logic signed [OPERAND_WIDTH-1:0] ln16,
      logic signed [OPERAND_WIDTH-1:0] ld16,
      logic signed [OPERAND_WIDTH-1:0] rn16,
      logic signed [OPERAND_WIDTH-1:0] rd16
   );
      cmd_type             op;
      longint              ln, ld, rn, rd, num, den, a, d, t;
      bit                  reduce;
      fraction_result_type r;
      op     = cmd_type'(op_bits);
      ln     = longint'(ln16);
      ld     = longint'(ld16);
      rn     = longint'(rn16);
      rd     = longint'(rd16);
      r      = '0;
      reduce = 1'b1;
      num    = 0;
      den    = 0;
      case (op)
         CMD_EQ: begin
            r.compare_true = (ln * rd == ld * rn);
            return r;
         end
         CMD_GT: begin
            r.compare_true = (ln * rd > ld * rn);
            return r;
         end
         CMD_LT: begin
            r.compare_true = (ln * rd < ld * rn);
            return r;
         end
         CMD_ADD, CMD_SUB: begin
            if (ld == rd) begin
               den = ld;
               num = (op == CMD_ADD) ? ln + rn : ln - rn;
            end else begin
               num = wrap_datapath(op == CMD_ADD ? ln * rd + ld * rn : ln * rd - ld * rn);
               den = wrap_datapath(ld * rd);
            end
         end
         CMD_MUL: begin
            num    = wrap_datapath(ln * rn);
            den    = wrap_datapath(ld * rd);
            reduce = 1'b0;
         end
         CMD_DIV: begin
            num = wrap_datapath(ln * rd);
            den = wrap_datapath(ld * rn);
         end
         default: return r;
      endcase
      if (den == 0) begin
         r.error = 1'b1;
         return r;
      end
      if (reduce) begin
         // Euclid on signed values, truncated remainder
         a = num;
         d = den;
         while (d != 0) begin
            t = d;
            d = a % d;
            a = t;
         end
         num = num / a;
         den = den / a;
      end
      r.num = num[RESULT_WIDTH-1:0];
      r.den = den[RESULT_WIDTH-1:0];
      return r;
   endfunction

   task automatic check_field(string field, logic signed [RESULT_WIDTH-1:0] want,
                              logic signed [RESULT_WIDTH-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      fraction_result_type want;
      if (reset) begin
         pending_results.delete();
      end else begin
         if (req_valid && !req_stall)
            pending_results.push_back(predict_fraction(req_command, req_left_num,
               req_left_den, req_right_num, req_right_den));
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response beat with no request outstanding", $time);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("result_num", want.num, rsp_result_num);
               check_field("result_den", want.den, rsp_result_den);
               check_field("compare_true", RESULT_WIDTH'(want.compare_true),
                           RESULT_WIDTH'(rsp_compare_true));
               check_field("error", RESULT_WIDTH'(want.error), RESULT_WIDTH'(rsp_error));
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= pending_results.size();
   end

endmodule

### dv/tb_rational_arithmetic_unit.sv
module tb_rational_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import rau_pkg::*;

   localparam int RANDOM_BEATS     = 350;
   localparam int QUIET_BEATS      = 40;      // tail of the run with no idling at all
   localparam int HOLD_AT_BEAT     = 60;      // random beat that triggers the long hold-off
   localparam int LONG_HOLD_CYCLES = 6000;    // covers several worst-case reductions
   localparam int DRAIN_CYCLES     = 2000;
   localparam int CYCLE_LIMIT      = 2_500_000;

   // no encoding in the package for 7; the block must answer with all zeros
   localparam logic [COMMAND_WIDTH-1:0] CMD_UNUSED = 3'd7;

   localparam logic signed [OPERAND_WIDTH-1:0] OP_MIN = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
   localparam logic signed [OPERAND_WIDTH-1:0] OP_MAX = ~OP_MIN;

   logic                                clock;
   logic                                reset         = 1'b1;
   logic                                req_valid     = 1'b0;
   logic                                req_stall;
   logic [COMMAND_WIDTH-1:0]            req_command   = '0;
   logic signed [OPERAND_WIDTH-1:0]     req_left_num  = '0;
   logic signed [OPERAND_WIDTH-1:0]     req_left_den  = '0;
   logic signed [OPERAND_WIDTH-1:0]     req_right_num = '0;
   logic signed [OPERAND_WIDTH-1:0]     req_right_den = '0;
   logic                                rsp_valid;
   logic                                rsp_stall     = 1'b0;
   logic signed [RESULT_WIDTH-1:0]      rsp_result_num;
   logic signed [RESULT_WIDTH-1:0]      rsp_result_den;
   logic                                rsp_compare_true;
   logic                                rsp_error;

   int fail_count;
   int pending_count;

   // quiet_tail and hold_request are shared between the request and response sides
   bit quiet_tail   = 1'b0;
   bit hold_request = 1'b0;
   bit send_calm    = 1'b0;

   rational_arithmetic_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_left_num     (req_left_num),
      .req_left_den     (req_left_den),
      .req_right_num    (req_right_num),
      .req_right_den    (req_right_den),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_num   (rsp_result_num),
      .rsp_result_den   (rsp_result_den),
      .rsp_compare_true (rsp_compare_true),
      .rsp_error        (rsp_error)
   );

   rau_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_left_num     (req_left_num),
      .req_left_den     (req_left_den),
      .req_right_num    (req_right_num),
      .req_right_den    (req_right_den),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_num   (rsp_result_num),
      .rsp_result_den   (rsp_result_den),
      .rsp_compare_true (rsp_compare_true),
      .rsp_error        (rsp_error),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Operand mix: zeros, extremes, small values (so the GCD actually
   // reduces something) and full-range noise.
   function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: begin
            case ($urandom_range(0, 3))
               0:       return OP_MIN;
               1:       return OP_MAX;
               2:       return OPERAND_WIDTH'(-1);
               default: return OPERAND_WIDTH'(1);
            endcase
         end
         2, 3, 4: return OPERAND_WIDTH'($urandom_range(0, 40) - 20);
         default: return OPERAND_WIDTH'($urandom);
      endcase
   endfunction

   // Offer one request beat and hold it until it is taken. Valid only drops
   // for a random gap at the start of a beat, never right after being raised.
   task automatic send_request(input logic [COMMAND_WIDTH-1:0] op,
                               input logic signed [OPERAND_WIDTH-1:0] ln,
                               input logic signed [OPERAND_WIDTH-1:0] ld,
                               input logic signed [OPERAND_WIDTH-1:0] rn,
                               input logic signed [OPERAND_WIDTH-1:0] rd);
      if ($urandom_range(0, 15) == 0)
         send_calm = !send_calm;
      if (!quiet_tail && !send_calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_command   <= op;
      req_left_num  <= ln;
      req_left_den  <= ld;
      req_right_num <= rn;
      req_right_den <= rd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [COMMAND_WIDTH-1:0]        op;
      logic signed [OPERAND_WIDTH-1:0] ln, ld, rn, rd;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed beats
      send_request(CMD_ADD, 1, 3, 1, 3);              // shared denominator
      send_request(CMD_ADD, 1, 2, 1, 3);              // cross-multiplied
      send_request(CMD_SUB, 5, 7, 5, 7);              // zero numerator reduces to 0/1
      send_request(CMD_SUB, 3, -4, 1, 6);             // negative denominator through GCD
      send_request(CMD_MUL, 2, 3, 3, 4);              // product left unreduced
      send_request(CMD_MUL, 1, 0, 1, 5);              // zero denominator -> error
      send_request(CMD_DIV, 1, 2, 3, 4);
      send_request(CMD_DIV, 1, 2, 0, 5);              // divide by zero fraction -> error
      send_request(CMD_ADD, 3, 0, 4, 0);              // equal zero denominators -> error
      send_request(CMD_SUB, 1, 0, 1, 5);              // cross product denominator zero
      send_request(CMD_EQ, 1, 2, 2, 4);
      send_request(CMD_EQ, 1, 2, 1, 3);
      send_request(CMD_GT, 1, -2, 1, 3);              // signs of denominators not fixed
      send_request(CMD_LT, -1, 3, 1, -3);
      send_request(CMD_ADD, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
      send_request(CMD_MUL, OP_MIN, OP_MIN, OP_MIN, OP_MIN);
      send_request(CMD_DIV, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
      send_request(CMD_ADD, OP_MAX, OP_MIN, OP_MIN, OP_MAX);
      send_request(CMD_SUB, OP_MAX, OP_MAX, OP_MIN, OP_MAX);
      send_request(CMD_GT, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
      send_request(CMD_LT, OP_MAX, 1, OP_MIN, 1);
      send_request(CMD_UNUSED, OP_MAX, 3, -7, OP_MIN);
      send_request(CMD_MUL, 0, 1, 0, 1);
      send_request(CMD_EQ, 0, 0, 0, 0);

      // Random beats
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n == HOLD_AT_BEAT)
            hold_request = 1'b1;
         if (n == RANDOM_BEATS - QUIET_BEATS)
            quiet_tail = 1'b1;
         op = COMMAND_WIDTH'($urandom_range(0, 6));
         ln = pick_operand();
         ld = pick_operand();
         rn = pick_operand();
         rd = pick_operand();
         case ($urandom_range(0, 9))
            0, 1, 2: rd = ld;                          // shared-denominator path
            3: begin                                   // identical fractions
               rn = ln;
               rd = ld;
            end
            4: begin                                   // same value, both signs flipped
               rn = -ln;
               rd = -ld;
            end
            default: ;
         endcase
         send_request(op, ln, ld, rn, rd);
      end
      req_valid <= 1'b0;

      // Let the checker see the last beat, then drain
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Response side: random stall bursts, calm stretches, and one long
   // hold-off so the result register fills, the block parks in FINISH and
   // req_stall stays up while requests keep coming.
   initial begin : response_side
      bit held;
      bit rsp_calm;
      held     = 1'b0;
      rsp_calm = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            if ($urandom_range(0, 15) == 0)
               rsp_calm = !rsp_calm;
            rsp_stall <= !quiet_tail && !rsp_calm && $urandom_range(0, 2) == 0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

endmodule
